### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define CHK_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// Implication checked on the next edge.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### design/rar_pkg.sv
// Package: widths, command codes and controller states for the rational unit.
`timescale 1ns / 1ps
package rar_pkg;
  localparam int IN_BITS  = 15;
  localparam int NUM_BITS = 31;
  localparam int DEN_BITS = 30;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_EVEN  = 7'b0000100,
    ST_GCD   = 7'b0001000,
    ST_SHIFT = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } rar_state_t;
endpackage

### design/rational_add_multiply_reduce.sv
// Top level: add or multiply two fractions and reduce the result to lowest terms.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid / in_stall  | cmd, a_num, a_den, b_num, b_den
//  out_    | result    | out_valid / out_stall| res_num, res_den, error
//
//  Steps per request: serial multiply, fold of the cross product, strip of the common
//  power of two, binary GCD steps, restore of that power of two, then two parallel
//  restoring divisions; EB = min(OPERAND_BITS,15) is the operand width, NW = 2*EB+1.
//  The GCD step count depends on the operands; a zero operand goes straight to an error result.
//  One request is in flight at a time; in_stall is high from accept until the
//  result is loaded into the output register, which holds it while out_stall is high.
//  Reset (synchronous, rst_n low) returns the controller to idle and drops out_valid.
module rational_add_multiply_reduce #(
  parameter int OPERAND_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [rar_pkg::IN_BITS-1:0]   in_a_num,
  input  logic [rar_pkg::IN_BITS-1:0]   in_a_den,
  input  logic [rar_pkg::IN_BITS-1:0]   in_b_num,
  input  logic [rar_pkg::IN_BITS-1:0]   in_b_den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rar_pkg::NUM_BITS-1:0]  out_res_num,
  output logic [rar_pkg::DEN_BITS-1:0]  out_res_den,
  output logic                          out_error
);
  import rar_pkg::*;

  // Effective operand width: ports carry at most IN_BITS.
  localparam int EB = (OPERAND_BITS < IN_BITS) ? OPERAND_BITS : IN_BITS;
  localparam int NW = 2 * EB + 1;          // unreduced numerator width
  localparam int CW = $clog2(NW + 1);      // step and shift counters

  rar_state_t state_r, state_nxt;

  // Serial multiplier: multiplicands shift left, multipliers shift right.
  logic [NW-1:0] mc1_r, mc2_r, mc3_r, mc1_nxt, mc2_nxt, mc3_nxt;
  logic [EB-1:0] mp1_r, mp2_r, mp3_r, mp1_nxt, mp2_nxt, mp3_nxt;
  // acc1 holds the numerator then its quotient, acc3 the denominator likewise.
  logic [NW-1:0] acc1_r, acc2_r, acc3_r, acc1_nxt, acc2_nxt, acc3_nxt;
  // GCD working pair; gv ends up as the divisor.
  logic [NW-1:0] gu_r, gv_r, gu_nxt, gv_nxt;
  logic [CW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic [NW:0]   remn_r, remd_r, remn_nxt, remd_nxt;
  logic          err_r, err_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [NUM_BITS-1:0] out_num_r, out_num_nxt;
  logic [DEN_BITS-1:0] out_den_r, out_den_nxt;
  logic                out_err_r, out_err_nxt;

  logic [EB-1:0] an, ad, bn, bd;
  logic [NW:0]   tn, td;
  logic          in_take;

  assign an = in_a_num[EB-1:0];
  assign ad = in_a_den[EB-1:0];
  assign bn = in_b_num[EB-1:0];
  assign bd = in_b_den[EB-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Trial remainders for the two restoring divisions.
  assign tn = {remn_r[NW-1:0], acc1_r[NW-1]};
  assign td = {remd_r[NW-1:0], acc3_r[NW-1]};

  always_comb begin
    state_nxt = state_r;
    mc1_nxt = mc1_r; mc2_nxt = mc2_r; mc3_nxt = mc3_r;
    mp1_nxt = mp1_r; mp2_nxt = mp2_r; mp3_nxt = mp3_r;
    acc1_nxt = acc1_r; acc2_nxt = acc2_r; acc3_nxt = acc3_r;
    gu_nxt = gu_r; gv_nxt = gv_r;
    k_nxt = k_r; cnt_nxt = cnt_r;
    remn_nxt = remn_r; remd_nxt = remd_r;
    err_nxt = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_num_nxt = out_num_r;
    out_den_nxt = out_den_r;
    out_err_nxt = out_err_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          mc1_nxt  = NW'(an);
          mc2_nxt  = NW'(bn);
          mc3_nxt  = NW'(ad);
          mp1_nxt  = (in_cmd == CMD_MUL) ? bn : bd;
          mp2_nxt  = (in_cmd == CMD_MUL) ? '0 : ad;
          mp3_nxt  = bd;
          acc1_nxt = '0;
          acc2_nxt = '0;
          acc3_nxt = '0;
          cnt_nxt  = '0;
          err_nxt  = (an == '0) || (ad == '0) || (bn == '0) || (bd == '0);
          state_nxt = err_nxt ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mp1_r[0]) acc1_nxt = acc1_r + mc1_r;
        if (mp2_r[0]) acc2_nxt = acc2_r + mc2_r;
        if (mp3_r[0]) acc3_nxt = acc3_r + mc3_r;
        mc1_nxt = {mc1_r[NW-2:0], 1'b0};
        mc2_nxt = {mc2_r[NW-2:0], 1'b0};
        mc3_nxt = {mc3_r[NW-2:0], 1'b0};
        mp1_nxt = mp1_r >> 1;
        mp2_nxt = mp2_r >> 1;
        mp3_nxt = mp3_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(EB - 1)) begin
          state_nxt = ST_EVEN;
        end
      end
      ST_EVEN: begin
        // Fold the cross product in once, then strip common factors of two.
        if (cnt_r != '0) begin
          acc1_nxt = acc1_r + acc2_r;
          gu_nxt   = acc1_r + acc2_r;
          gv_nxt   = acc3_r;
          k_nxt    = '0;
          cnt_nxt  = '0;
        end else if (!gu_r[0] && !gv_r[0]) begin
          gu_nxt = gu_r >> 1;
          gv_nxt = gv_r >> 1;
          k_nxt  = k_r + 1'b1;
        end else begin
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gu_r == '0) begin
          state_nxt = ST_SHIFT;
        end else if (!gu_r[0]) begin
          gu_nxt = gu_r >> 1;
        end else if (!gv_r[0]) begin
          gv_nxt = gv_r >> 1;
        end else if (gu_r >= gv_r) begin
          gu_nxt = gu_r - gv_r;
        end else begin
          gv_nxt = gv_r - gu_r;
        end
      end
      ST_SHIFT: begin
        // Restore the common power of two, one bit a cycle.
        if (k_r == '0) begin
          remn_nxt  = '0;
          remd_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          gv_nxt = {gv_r[NW-2:0], 1'b0};
          k_nxt  = k_r - 1'b1;
        end
      end
      ST_DIV: begin
        if (tn >= {1'b0, gv_r}) begin
          remn_nxt = tn - {1'b0, gv_r};
          acc1_nxt = {acc1_r[NW-2:0], 1'b1};
        end else begin
          remn_nxt = tn;
          acc1_nxt = {acc1_r[NW-2:0], 1'b0};
        end
        if (td >= {1'b0, gv_r}) begin
          remd_nxt = td - {1'b0, gv_r};
          acc3_nxt = {acc3_r[NW-2:0], 1'b1};
        end else begin
          remd_nxt = td;
          acc3_nxt = {acc3_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand over once the output register is free.
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_num_nxt   = err_r ? '0 : NUM_BITS'(acc1_r);
          out_den_nxt   = err_r ? '0 : DEN_BITS'(acc3_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc1_r <= mc1_nxt; mc2_r <= mc2_nxt; mc3_r <= mc3_nxt;
    mp1_r <= mp1_nxt; mp2_r <= mp2_nxt; mp3_r <= mp3_nxt;
    acc1_r <= acc1_nxt; acc2_r <= acc2_nxt; acc3_r <= acc3_nxt;
    gu_r <= gu_nxt; gv_r <= gv_nxt;
    k_r <= k_nxt; cnt_r <= cnt_nxt;
    remn_r <= remn_nxt; remd_r <= remd_nxt;
    err_r <= err_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_error   = out_err_r;
endmodule

### design/rar_checker.sv
// Port-level checker for the rational unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rar_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rar_pkg::NUM_BITS-1:0]  out_res_num,
  input logic [rar_pkg::DEN_BITS-1:0]  out_res_den,
  input logic                          out_error
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_res_num) && $stable(out_res_den) && $stable(out_error))
  `CHK_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_SAME(a_err_zero, clk, rst_n, out_valid && out_error, out_res_num == '0 && out_res_den == '0)
  `CHK_SAME(a_den_nonzero, clk, rst_n, out_valid && !out_error, out_res_den != '0 && out_res_num != '0)
endmodule

bind rational_add_multiply_reduce rar_checker u_rar_checker (.*);
